// ----- rtl/route_pending_packet_buffer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Route pending packet buffer: assertion macros
// Shared forms for the concurrent checks on the top level ports.
// ----------------------------------------------------------------------------
`ifndef ROUTE_PENDING_PACKET_BUFFER_TOP_DEFINES_SVH
`define ROUTE_PENDING_PACKET_BUFFER_TOP_DEFINES_SVH

// same-cycle implication, inactive while in reset
`define RPPB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rppb check failed");

// next-cycle implication, inactive while in reset
`define RPPB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rppb check failed");

`endif

// ----- rtl/rppb_pkg.sv -----
// ----------------------------------------------------------------------------
// rppb_pkg
// Types, codes and sizes shared by the route pending packet buffer.
// ----------------------------------------------------------------------------
package rppb_pkg;

    localparam int DEPTH       = 32;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_VERD  = 2'd1;
    localparam logic [1:0] OP_SWEEP = 2'd2;
    localparam logic [1:0] OP_FLUSH = 2'd3;

    localparam logic [1:0] V_SEND = 2'd0;
    localparam logic [1:0] V_ENC  = 2'd1;
    localparam logic [1:0] V_DROP = 2'd2;

    localparam logic [1:0] ACT_FWD  = 2'd0;
    localparam logic [1:0] ACT_ENC  = 2'd1;
    localparam logic [1:0] ACT_DROP = 2'd2;
    localparam logic [1:0] ACT_SUM  = 2'd3;

    localparam logic [1:0] CFG_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_MAX_AGE = 2'd1;
    localparam logic [1:0] CFG_MAC     = 2'd2;
    localparam logic [1:0] CFG_GATEWAY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_EMIT,
        S_APPEND,
        S_SUM
    } state_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] hnd;
        logic [31:0]            dst;
        logic [31:0]            stamp;
        logic                   is_ip;
    } entry_t;

    typedef struct packed {
        logic latch;
        logic clr_walk;
        logic count_step;
        logic emit_step;
        logic walk_end;
        logic append;
        logic send_sum;
    } cmd_t;

    typedef struct packed {
        logic       walk_done;
        logic       out_free;
        logic       evict_in;
        logic       err_in;
        logic [1:0] op_in;
        logic [1:0] op_cur;
    } sts_t;

endpackage

// ----- rtl/route_pending_packet_buffer_top.sv -----
// ----------------------------------------------------------------------------
// route_pending_packet_buffer_top
// Ordered buffer of packet handles awaiting a route.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one operation item: add, verdict,
// age sweep or flush. Output channel (out_valid/out_ready) returns one item
// per entry removed (a flush gives none), then a summary item with last_result set.
// The block works on one operation at a time; in_ready is high only when idle.
// Verdict and sweep walk the stored entries twice, once to count removals and
// once to emit and compact; a verdict to send with no route found skips both
// walks. An add that evicts walks once to remove the oldest entry; a plain add
// and a flush do not walk.
// A stalled receiver holds the output register and pauses the walk on the next
// removed entry; kept entries still move down meanwhile.
// Reset empties the queue and loads the register defaults: limit 32, maximum
// age 10000 ms, IP mode, gateway 0. Write configuration only while idle.
// ----------------------------------------------------------------------------
module route_pending_packet_buffer_top
    import rppb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic [HANDLE_BITS-1:0] packet_handle,
    input  logic [31:0]            dest_address,
    input  logic [1:0]             verdict,
    input  logic                   route_found,
    input  logic                   is_ip_datagram,
    input  logic [31:0]            current_time,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [HANDLE_BITS-1:0] packet_handle_out,
    output logic [1:0]             action,
    output logic [5:0]             send_slot,
    output logic [31:0]            tunnel_address,
    output logic [5:0]             processed_count,
    output logic                   status,
    output logic [5:0]             queue_length,
    output logic                   last_result
);

    cmd_t cmd;
    sts_t sts;

    rppb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rppb_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .opcode            (opcode),
        .packet_handle     (packet_handle),
        .dest_address      (dest_address),
        .verdict           (verdict),
        .route_found       (route_found),
        .is_ip_datagram    (is_ip_datagram),
        .current_time      (current_time),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .packet_handle_out (packet_handle_out),
        .action            (action),
        .send_slot         (send_slot),
        .tunnel_address    (tunnel_address),
        .processed_count   (processed_count),
        .status            (status),
        .queue_length      (queue_length),
        .last_result       (last_result)
    );

endmodule

// ----- rtl/rppb_ctrl.sv -----
// ----------------------------------------------------------------------------
// rppb_ctrl
// Sequencer: accepts an item, runs the count and compaction walks that the
// operation needs, closes with the summary item.
// ----------------------------------------------------------------------------
module rppb_ctrl
    import rppb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (sts.op_in == OP_FLUSH || sts.err_in)
                        state_next = S_SUM;
                    else if (sts.op_in == OP_ADD)
                        state_next = sts.evict_in ? S_EMIT : S_APPEND;
                    else
                        state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (sts.walk_done)
                begin
                    cmd.clr_walk = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    cmd.count_step = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (sts.walk_done)
                begin
                    cmd.walk_end = 1'b1;
                    state_next   = (sts.op_cur == OP_ADD) ? S_APPEND : S_SUM;
                end
                else
                begin
                    cmd.emit_step = 1'b1;
                end
            end
            S_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (sts.out_free)
                begin
                    cmd.send_sum = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/rppb_datapath.sv -----
// ----------------------------------------------------------------------------
// rppb_datapath
// Entry store, walk counters, configuration registers and output register.
// ----------------------------------------------------------------------------
module rppb_datapath
    import rppb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   cfg_write_en,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic [1:0]             opcode,
    input  logic [HANDLE_BITS-1:0] packet_handle,
    input  logic [31:0]            dest_address,
    input  logic [1:0]             verdict,
    input  logic                   route_found,
    input  logic                   is_ip_datagram,
    input  logic [31:0]            current_time,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [HANDLE_BITS-1:0] packet_handle_out,
    output logic [1:0]             action,
    output logic [5:0]             send_slot,
    output logic [31:0]            tunnel_address,
    output logic [5:0]             processed_count,
    output logic                   status,
    output logic [5:0]             queue_length,
    output logic                   last_result
);

    entry_t mem [DEPTH];

    logic [5:0]  limit_reg;
    logic [31:0] max_age_reg;
    logic        mac_reg;
    logic [31:0] gateway_reg;

    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] wr_reg;
    logic [CNT_W-1:0] kill_cnt_reg;
    logic [CNT_W-1:0] slot_reg;
    logic             out_valid_reg;

    logic [1:0]             op_reg;
    logic [HANDLE_BITS-1:0] hnd_reg;
    logic [31:0]            dst_reg;
    logic [1:0]             verd_reg;
    logic                   isip_reg;
    logic [31:0]            now_reg;
    logic                   err_reg;
    logic                   evict_reg;

    logic [HANDLE_BITS-1:0] o_hnd_reg;
    logic [1:0]             o_act_reg;
    logic [5:0]             o_slot_reg;
    logic [31:0]            o_tun_reg;
    logic [5:0]             o_cnt_reg;
    logic                   o_st_reg;
    logic [5:0]             o_len_reg;
    logic                   o_last_reg;

    entry_t           rd;
    logic [31:0]      age;
    logic             kill;
    logic             is_send;
    logic [1:0]       kill_act;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] final_len;
    logic             out_free;
    logic             load_entry;

    assign rd       = mem[idx_reg[IDX_W-1:0]];
    assign age      = now_reg - rd.stamp;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        case (op_reg)
            OP_VERD:  kill = (rd.dst == dst_reg);
            OP_SWEEP: kill = (age > max_age_reg);
            OP_ADD:   kill = evict_reg && (idx_reg == '0);
            default:  kill = 1'b0;
        endcase
    end

    always_comb
    begin
        kill_act = ACT_DROP;
        if (op_reg == OP_VERD)
        begin
            if (verd_reg == V_SEND)
                kill_act = ACT_FWD;
            else if (verd_reg == V_ENC && !mac_reg && rd.is_ip)
                kill_act = ACT_ENC;
        end
    end
    assign is_send = (kill_act == ACT_FWD) || (kill_act == ACT_ENC);

    // limit of zero acts as one, above the store depth as the depth
    always_comb
    begin
        if (limit_reg == '0)
            lim = CNT_W'(1);
        else if ({1'b0, limit_reg} > 7'(DEPTH))
            lim = CNT_W'(DEPTH);
        else
            lim = CNT_W'(limit_reg);
    end

    assign final_len  = occ_reg - kill_cnt_reg + CNT_W'(op_reg == OP_ADD);
    assign load_entry = cmd.emit_step && (idx_reg != occ_reg) && kill && out_free;

    assign sts.walk_done = (idx_reg == occ_reg);
    assign sts.out_free  = out_free;
    assign sts.evict_in  = (opcode == OP_ADD) && (occ_reg >= lim);
    assign sts.err_in    = (opcode == OP_VERD) && (verdict == V_SEND) && !route_found;
    assign sts.op_in     = opcode;
    assign sts.op_cur    = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= 6'd32;
            max_age_reg <= 32'd10000;
            mac_reg     <= 1'b0;
            gateway_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_LIMIT:   limit_reg   <= cfg_data[5:0];
                CFG_MAX_AGE: max_age_reg <= cfg_data;
                CFG_MAC:     mac_reg     <= cfg_data[0];
                CFG_GATEWAY: gateway_reg <= cfg_data;
                default:     mac_reg     <= mac_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            idx_reg       <= '0;
            wr_reg        <= '0;
            kill_cnt_reg  <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_entry || cmd.send_sum)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cmd.latch)
            begin
                idx_reg      <= '0;
                wr_reg       <= '0;
                slot_reg     <= '0;
                kill_cnt_reg <= CNT_W'(sts.evict_in);
            end
            if (cmd.clr_walk)
            begin
                idx_reg  <= '0;
                wr_reg   <= '0;
                slot_reg <= '0;
            end
            if (cmd.count_step && !sts.walk_done)
            begin
                idx_reg      <= idx_reg + CNT_W'(1);
                kill_cnt_reg <= kill_cnt_reg + CNT_W'(kill);
            end
            if (cmd.emit_step && !sts.walk_done)
            begin
                if (!kill)
                begin
                    wr_reg  <= wr_reg + CNT_W'(1);
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                else if (out_free)
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                    if (is_send)
                        slot_reg <= slot_reg + CNT_W'(1);
                end
            end
            if (cmd.walk_end)
                occ_reg <= wr_reg;
            if (cmd.append)
                occ_reg <= occ_reg + CNT_W'(1);
            if (cmd.send_sum && op_reg == OP_FLUSH)
                occ_reg <= '0;
        end
    end

    // entry store: copy kept entries down, append at the tail
    always_ff @(posedge clk)
    begin
        if (cmd.emit_step && !sts.walk_done && !kill)
            mem[wr_reg[IDX_W-1:0]] <= rd;
        else if (cmd.append)
            mem[occ_reg[IDX_W-1:0]] <= '{hnd: hnd_reg, dst: dst_reg,
                                          stamp: now_reg, is_ip: isip_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= opcode;
            hnd_reg   <= packet_handle;
            dst_reg   <= dest_address;
            verd_reg  <= verdict;
            isip_reg  <= is_ip_datagram;
            now_reg   <= current_time;
            err_reg   <= sts.err_in;
            evict_reg <= sts.evict_in;
        end
        if (load_entry)
        begin
            o_hnd_reg  <= rd.hnd;
            o_act_reg  <= kill_act;
            o_slot_reg <= is_send ? 6'(slot_reg) : '0;
            o_tun_reg  <= (kill_act == ACT_ENC) ? gateway_reg : '0;
            o_cnt_reg  <= '0;
            o_st_reg   <= 1'b0;
            o_len_reg  <= 6'(final_len);
            o_last_reg <= 1'b0;
        end
        else if (cmd.send_sum)
        begin
            o_hnd_reg  <= '0;
            o_act_reg  <= ACT_SUM;
            o_slot_reg <= '0;
            o_tun_reg  <= '0;
            o_cnt_reg  <= (op_reg == OP_FLUSH) ? 6'(occ_reg) : 6'(kill_cnt_reg);
            o_st_reg   <= err_reg;
            o_len_reg  <= (op_reg == OP_FLUSH) ? '0 : 6'(occ_reg);
            o_last_reg <= 1'b1;
        end
    end

    assign out_valid         = out_valid_reg;
    assign packet_handle_out = o_hnd_reg;
    assign action            = o_act_reg;
    assign send_slot         = o_slot_reg;
    assign tunnel_address    = o_tun_reg;
    assign processed_count   = o_cnt_reg;
    assign status            = o_st_reg;
    assign queue_length      = o_len_reg;
    assign last_result       = o_last_reg;

endmodule

// ----- rtl/rppb_checker.sv -----
// ----------------------------------------------------------------------------
// rppb_checker
// Port-level checks on the route pending packet buffer.
// ----------------------------------------------------------------------------
`include "route_pending_packet_buffer_top_defines.svh"

module rppb_checker
    import rppb_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [HANDLE_BITS-1:0] packet_handle_out,
    input logic [1:0]             action,
    input logic [5:0]             processed_count,
    input logic [5:0]             queue_length,
    input logic                   last_result
);

    `RPPB_ASSERT_NOW(a_sum_is_last, out_valid && action == ACT_SUM, last_result)
    `RPPB_ASSERT_NOW(a_entry_plain, out_valid && action != ACT_SUM,
                     !last_result && processed_count == '0)
    `RPPB_ASSERT_NOW(a_busy_mid_op, out_valid && !last_result, !in_ready)
    `RPPB_ASSERT_NOW(a_len_bound, out_valid, queue_length <= 6'(DEPTH))
    `RPPB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
                      out_valid && $stable(packet_handle_out))

endmodule

bind route_pending_packet_buffer_top rppb_checker u_rppb_checker (.*);
